// ===== hdl/psd_pkg.sv =====
// Shared types and constants for the point to segment distance pipeline.
package psd_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int DIST_BITS  = 25;

	typedef enum logic [1:0] {
		CASE_DEGEN    = 2'd0,
		CASE_NEAR_A   = 2'd1,
		CASE_NEAR_B   = 2'd2,
		CASE_INTERIOR = 2'd3
	} case_t;

	typedef struct packed {
		logic  valid;
		case_t kind;
	} tag_t;

endpackage

// ===== hdl/point_segment_distance.sv =====
// Top level of the point to segment distance pipeline.
// Takes one request per cycle while the output is not stalled and returns one result per
// request, in order. The pipeline is five geometry stages, then a divider giving one quotient
// bit per stage and a square root giving one root bit per stage.
// A stalled output holds the whole pipeline; bubbles are not squeezed out.
module point_segment_distance #(
	parameter int COORD_BITS = psd_pkg::COORD_BITS,
	parameter int FRAC_BITS  = psd_pkg::FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [COORD_BITS-1:0]        seg_start_x,
	input  logic signed [COORD_BITS-1:0]        seg_start_y,
	input  logic signed [COORD_BITS-1:0]        seg_end_x,
	input  logic signed [COORD_BITS-1:0]        seg_end_y,
	input  logic signed [COORD_BITS-1:0]        point_x,
	input  logic signed [COORD_BITS-1:0]        point_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [psd_pkg::DIST_BITS-1:0]       distance,
	output logic [1:0]                          nearest_case
);
	import psd_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int D  = COORD_BITS + 1;
	localparam int P  = 2 * D;
	localparam int QW = 2 * D + 2 * FRAC_BITS;
	localparam int RW = QW / 2;
	localparam int XW = (RW > DIST_BITS) ? RW : DIST_BITS;

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: differences
	logic                v_s1;
	logic signed [D-1:0] abx_s1, aby_s1, apx_s1, apy_s1, bpx_s1, bpy_s1;

	// stage 2: products
	logic                v_s2, degen_s2;
	logic signed [P-1:0] dot_x_s2, dot_y_s2, ab_xx_s2, ab_yy_s2, cr_a_s2, cr_b_s2;
	logic signed [P-1:0] ap_xx_s2, ap_yy_s2, bp_xx_s2, bp_yy_s2;

	// stage 3: sums
	logic                v_s3, degen_s3;
	logic signed [P:0]   dot_s3, cross_s3;
	logic [P-1:0]        len2_s3, sqa_s3, sqb_s3;

	// stage 4: case decision and multiplier operands
	tag_t                tag_s4;
	logic [P-1:0]        mul_a_s4, mul_b_s4, den_s4;
	logic [P:0]          cross_abs;
	case_t               kind;

	// stage 5: numerator
	tag_t                tag_s5;
	logic [2*P-1:0]      num_s5;
	logic [P-1:0]        den_s5;

	tag_t                div_tag;
	logic [QW-1:0]       quo;
	tag_t                sq_tag;
	logic [RW-1:0]       root;
	logic [XW-1:0]       root_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else if (adv) begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			tag_s4 <= '{valid: v_s3, kind: kind};
			tag_s5 <= tag_s4;
		end
	end

	assign cross_abs = cross_s3[P] ? -cross_s3 : cross_s3;

	always_comb begin
		if (degen_s3) begin
			kind = CASE_DEGEN;
		end else if (dot_s3[P]) begin
			kind = CASE_NEAR_A;
		end else if ($signed(dot_s3) > $signed({1'b0, len2_s3})) begin
			kind = CASE_NEAR_B;
		end else begin
			kind = CASE_INTERIOR;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			abx_s1   <= {seg_end_x[C-1], seg_end_x} - {seg_start_x[C-1], seg_start_x};
			aby_s1   <= {seg_end_y[C-1], seg_end_y} - {seg_start_y[C-1], seg_start_y};
			apx_s1   <= {point_x[C-1], point_x} - {seg_start_x[C-1], seg_start_x};
			apy_s1   <= {point_y[C-1], point_y} - {seg_start_y[C-1], seg_start_y};
			bpx_s1   <= {point_x[C-1], point_x} - {seg_end_x[C-1], seg_end_x};
			bpy_s1   <= {point_y[C-1], point_y} - {seg_end_y[C-1], seg_end_y};

			degen_s2 <= (abx_s1 == '0) && (aby_s1 == '0);
			dot_x_s2 <= abx_s1 * apx_s1;
			dot_y_s2 <= aby_s1 * apy_s1;
			ab_xx_s2 <= abx_s1 * abx_s1;
			ab_yy_s2 <= aby_s1 * aby_s1;
			cr_a_s2  <= abx_s1 * apy_s1;
			cr_b_s2  <= aby_s1 * apx_s1;
			ap_xx_s2 <= apx_s1 * apx_s1;
			ap_yy_s2 <= apy_s1 * apy_s1;
			bp_xx_s2 <= bpx_s1 * bpx_s1;
			bp_yy_s2 <= bpy_s1 * bpy_s1;

			degen_s3 <= degen_s2;
			dot_s3   <= {dot_x_s2[P-1], dot_x_s2} + {dot_y_s2[P-1], dot_y_s2};
			cross_s3 <= {cr_a_s2[P-1], cr_a_s2} - {cr_b_s2[P-1], cr_b_s2};
			len2_s3  <= ab_xx_s2 + ab_yy_s2;
			sqa_s3   <= ap_xx_s2 + ap_yy_s2;
			sqb_s3   <= bp_xx_s2 + bp_yy_s2;

			// interior foot squares the cross product, endpoints pass through times one
			unique case (kind)
				CASE_INTERIOR: begin
					mul_a_s4 <= cross_abs[P-1:0];
					mul_b_s4 <= cross_abs[P-1:0];
					den_s4   <= len2_s3;
				end
				CASE_NEAR_B: begin
					mul_a_s4 <= sqb_s3;
					mul_b_s4 <= P'(1);
					den_s4   <= P'(1);
				end
				default: begin
					mul_a_s4 <= sqa_s3;
					mul_b_s4 <= P'(1);
					den_s4   <= P'(1);
				end
			endcase

			num_s5 <= mul_a_s4 * mul_b_s4;
			den_s5 <= den_s4;
		end
	end

	psd_div #(
		.DEN_BITS(P),
		.QUO_BITS(QW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.tag_in (tag_s5),
		.num    ((QW + P)'(num_s5) << (2 * FRAC_BITS)),
		.den    (den_s5),
		.tag_out(div_tag),
		.quo    (quo)
	);

	psd_isqrt #(
		.RAD_BITS(QW)
	) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.tag_in (div_tag),
		.rad    (quo),
		.tag_out(sq_tag),
		.root   (root)
	);

	// saturate a root that does not fit the output
	assign root_ext     = XW'(root);
	assign distance     = (root_ext > XW'({DIST_BITS{1'b1}})) ? {DIST_BITS{1'b1}}
	                                                          : root_ext[DIST_BITS-1:0];
	assign nearest_case = sq_tag.kind;
	assign out_valid    = sq_tag.valid;

`ifndef SYNTHESIS
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(tag_s5) && $stable(v_s1))
		else $error("pipeline moved while output stalled");

	a_interior_den: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_s4.valid && tag_s4.kind == CASE_INTERIOR) |-> den_s4 != '0)
		else $error("zero divisor on interior foot");
`endif

endmodule

// ===== hdl/psd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module psd_div #(
	parameter int DEN_BITS = 34,
	parameter int QUO_BITS = 50
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  psd_pkg::tag_t                tag_in,
	input  logic [DEN_BITS+QUO_BITS-1:0] num,
	input  logic [DEN_BITS-1:0]          den,
	output psd_pkg::tag_t                tag_out,
	output logic [QUO_BITS-1:0]          quo
);
	import psd_pkg::*;

	// remainder, then numerator bits shifting out while quotient bits shift in
	logic [DEN_BITS-1:0] rem_s [QUO_BITS+1];
	logic [QUO_BITS-1:0] nq_s  [QUO_BITS+1];
	logic [DEN_BITS-1:0] den_s [QUO_BITS+1];
	tag_t                tag_s [QUO_BITS+1];

	assign rem_s[0] = num[DEN_BITS+QUO_BITS-1:QUO_BITS];
	assign nq_s[0]  = num[QUO_BITS-1:0];
	assign den_s[0] = den;
	assign tag_s[0] = tag_in;

	for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
		logic [DEN_BITS:0] trial;
		logic [DEN_BITS:0] diff;
		logic              ge;

		assign trial = {rem_s[i], nq_s[i][QUO_BITS-1]};
		assign diff  = trial - {1'b0, den_s[i]};
		assign ge    = trial >= {1'b0, den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i+1] <= '0;
			end else if (adv) begin
				tag_s[i+1] <= tag_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1] <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
				nq_s[i+1]  <= {nq_s[i][QUO_BITS-2:0], ge};
				den_s[i+1] <= den_s[i];
			end
		end
	end

	assign tag_out = tag_s[QUO_BITS];
	assign quo     = nq_s[QUO_BITS];

endmodule

// ===== hdl/psd_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module psd_isqrt #(
	parameter int RAD_BITS = 50
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  psd_pkg::tag_t         tag_in,
	input  logic [RAD_BITS-1:0]   rad,
	output psd_pkg::tag_t         tag_out,
	output logic [RAD_BITS/2-1:0] root
);
	import psd_pkg::*;

	localparam int R = RAD_BITS / 2;

	logic [R+1:0]        rem_s  [R+1];
	logic [R-1:0]        root_s [R+1];
	logic [RAD_BITS-1:0] x_s    [R+1];
	tag_t                tag_s  [R+1];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign x_s[0]    = rad;
	assign tag_s[0]  = tag_in;

	for (genvar j = 0; j < R; j++) begin : g_stage
		logic [R+3:0] t;
		logic [R+3:0] trial;
		logic [R+3:0] diff;
		logic         ge;

		assign t     = {rem_s[j], x_s[j][RAD_BITS-1:RAD_BITS-2]};
		assign trial = {2'b00, root_s[j], 2'b01};
		assign diff  = t - trial;
		assign ge    = t >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[j+1] <= '0;
			end else if (adv) begin
				tag_s[j+1] <= tag_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j+1]  <= ge ? diff[R+1:0] : t[R+1:0];
				root_s[j+1] <= {root_s[j][R-2:0], ge};
				x_s[j+1]    <= {x_s[j][RAD_BITS-3:0], 2'b00};
			end
		end
	end

	assign tag_out = tag_s[R];
	assign root    = root_s[R];

endmodule
